FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gakf_pkg.sv
package gakf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W = 32;
  localparam int REG_W = 24;
  localparam int DT_W = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0] Q_ANGLE_RST = 24'd655;
  localparam logic [REG_W-1:0] Q_BIAS_RST = 24'd2621;
  localparam logic [REG_W-1:0] R_MEAS_RST = 24'd19661;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_BIAS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R_MEAS = 2'd2;

  // shared ALU operations
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } alu_op_t;

  localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] MIN32 = 32'sh80000000;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat66(input logic signed [65:0] v);
    if (v > 66'sh0_7fff_ffff) begin
      return MAX32;
    end else if (v < -66'sh0_8000_0000) begin
      return MIN32;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/gakf_alu.sv
// Shared saturating add / subtract / fixed-point multiply, result registered
module gakf_alu #(
  parameter int FRAC_BITS = gakf_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  gakf_pkg::alu_op_t                      op,
  input  logic signed [gakf_pkg::DATA_W-1:0]     a,
  input  logic signed [gakf_pkg::DATA_W-1:0]     b,
  output logic signed [gakf_pkg::DATA_W-1:0]     res
);

  logic signed [63:0] prod;
  logic signed [65:0] rnd;
  logic signed [65:0] sum;
  logic signed [gakf_pkg::DATA_W-1:0] res_next;

  always_comb begin
    prod = 64'(a) * 64'(b);
    rnd = (66'(prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    sum = '0;
    unique case (op)
      gakf_pkg::OP_ADD: sum = 66'(a) + 66'(b);
      gakf_pkg::OP_SUB: sum = 66'(a) - 66'(b);
      gakf_pkg::OP_MUL: sum = rnd;
      default:          sum = '0;
    endcase
    res_next = gakf_pkg::sat66(sum);
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

FILE: rtl/core/gakf_div.sv
// Restoring divider: (num << FRAC_BITS) / den, signed, truncated, saturated.
// One quotient bit per cycle.
module gakf_div #(
  parameter int FRAC_BITS = gakf_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [gakf_pkg::DATA_W-1:0]     num,
  input  logic signed [gakf_pkg::DATA_W-1:0]     den,
  output logic                                   done,
  output logic signed [gakf_pkg::DATA_W-1:0]     quo
);

  localparam int NW = gakf_pkg::DATA_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dividend;
  logic [NW-1:0] q;
  logic [gakf_pkg::DATA_W:0] rem;
  logic [gakf_pkg::DATA_W-1:0] dmag;
  logic neg;
  logic zero;
  logic busy;
  logic [CW-1:0] cnt;
  logic [gakf_pkg::DATA_W+1:0] trial;
  logic signed [NW+1:0] sq;

  assign trial = {rem, dividend[NW-1]} - {2'b00, dmag};

  always_comb begin
    sq = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (zero) begin
      quo = '0;
    end else if (sq > $signed((NW+2)'(gakf_pkg::MAX32))) begin
      quo = gakf_pkg::MAX32;
    end else if (sq < $signed((NW+2)'(gakf_pkg::MIN32))) begin
      quo = gakf_pkg::MIN32;
    end else begin
      quo = sq[gakf_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse on the last quotient bit
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NW);
        neg <= num[gakf_pkg::DATA_W-1] ^ den[gakf_pkg::DATA_W-1];
        zero <= (den == '0);
        dividend <= {(num[gakf_pkg::DATA_W-1] ? gakf_pkg::DATA_W'(-num) : num),
                     FRAC_BITS'(0)};
        dmag <= den[gakf_pkg::DATA_W-1] ? gakf_pkg::DATA_W'(-den) : den;
        rem <= '0;
        q <= '0;
      end else if (busy) begin
        if (!trial[gakf_pkg::DATA_W+1]) begin
          rem <= trial[gakf_pkg::DATA_W:0];
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[gakf_pkg::DATA_W-1:0], dividend[NW-1]};
          q <= {q[NW-2:0], 1'b0};
        end
        dividend <= {dividend[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_div_busy, clk, rst, start, busy, "divider did not start")
  `ASSERT_IMPL(a_div_no_overlap, clk, rst, done, !busy, "done while busy")
  `ASSERT_IMPL(a_div_cnt, clk, rst, busy && !start, cnt != '0, "divider count ran out")

endmodule

FILE: rtl/core/gyro_angle_kalman_filter.sv
// Channel | Direction | Signals
// --------+-----------+-----------------------------------------------
// in      | sink      | in_valid/in_ready: rate_sample, measured_angle, time_step
// out     | source    | out_valid/out_ready: angle_estimate, bias_estimate
// cfg     | sink      | cfg_valid/cfg_ready: cfg_index, cfg_data
//
// One word takes 28 ALU steps, 5 copy/spare steps and two divides; the divider takes most of the time.
// in_ready is high only in idle; the result sits in an output register until taken,
// and the next word is accepted once the output is taken.
// Synchronous active-high reset clears state, covariance and registers to defaults.
module gyro_angle_kalman_filter #(
  parameter int FRAC_BITS = gakf_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [gakf_pkg::DATA_W-1:0]         rate_sample,
  input  logic signed [gakf_pkg::DATA_W-1:0]         measured_angle,
  input  logic [gakf_pkg::DT_W-1:0]                  time_step,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [gakf_pkg::DATA_W-1:0]         angle_estimate,
  output logic signed [gakf_pkg::DATA_W-1:0]         bias_estimate,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [gakf_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [gakf_pkg::REG_W-1:0]                 cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WB,
    S_DIV,
    S_OUT
  } state_t;

  // scratch register file
  typedef enum logic [3:0] {
    R_ANG, R_BIAS, R_AA, R_AB, R_BA, R_BB,
    R_RATE, R_MEAS, R_DT, R_T, R_U, R_S, R_K0, R_K1, R_P00, R_P01
  } reg_t;

  typedef struct packed {
    gakf_pkg::alu_op_t op;
    reg_t              a;
    reg_t              b;
    logic              b_cfg;   // use a config register for operand b
    logic [1:0]        cfg_sel;
    reg_t              d;
  } uop_t;

  localparam int NSTEP = 28;
  localparam int PCW = $clog2(NSTEP);
  localparam int DIV0 = 21;  // divide steps in program
  localparam int DIV1 = 22;

  state_t state;
  logic [PCW-1:0] pc;
  logic signed [gakf_pkg::DATA_W-1:0] rf [16];
  logic [gakf_pkg::REG_W-1:0] q_angle, q_bias, r_meas;
  uop_t u;
  logic signed [gakf_pkg::DATA_W-1:0] opa, opb, alu_res, div_q;
  logic div_start, div_done;

  // microprogram
  always_comb begin
    u = '{gakf_pkg::OP_ADD, R_T, R_T, 1'b0, 2'd0, R_T};
    unique case (pc)
      5'd0:  u = '{gakf_pkg::OP_SUB, R_RATE, R_BIAS, 1'b0, 2'd0, R_T};
      5'd1:  u = '{gakf_pkg::OP_MUL, R_DT, R_T, 1'b0, 2'd0, R_T};
      5'd2:  u = '{gakf_pkg::OP_ADD, R_ANG, R_T, 1'b0, 2'd0, R_ANG};
      5'd3:  u = '{gakf_pkg::OP_ADD, R_BA, R_AB, 1'b0, 2'd0, R_T};
      5'd4:  u = '{gakf_pkg::OP_MUL, R_DT, R_T, 1'b0, 2'd0, R_T};
      5'd5:  u = '{gakf_pkg::OP_SUB, R_AA, R_T, 1'b0, 2'd0, R_AA};
      5'd6:  u = '{gakf_pkg::OP_MUL, R_DT, R_DT, 1'b0, 2'd0, R_U};
      5'd7:  u = '{gakf_pkg::OP_MUL, R_U, R_BB, 1'b0, 2'd0, R_U};
      5'd8:  u = '{gakf_pkg::OP_ADD, R_AA, R_U, 1'b0, 2'd0, R_AA};
      5'd9:  u = '{gakf_pkg::OP_ADD, R_AA, R_T, 1'b1, 2'd0, R_AA};
      5'd10: u = '{gakf_pkg::OP_MUL, R_DT, R_BB, 1'b0, 2'd0, R_T};
      5'd11: u = '{gakf_pkg::OP_SUB, R_AB, R_T, 1'b0, 2'd0, R_AB};
      5'd12: u = '{gakf_pkg::OP_SUB, R_BA, R_T, 1'b0, 2'd0, R_BA};
      5'd13: u = '{gakf_pkg::OP_ADD, R_BB, R_T, 1'b1, 2'd1, R_BB};
      5'd14: u = '{gakf_pkg::OP_SUB, R_MEAS, R_ANG, 1'b0, 2'd0, R_U};
      5'd15: u = '{gakf_pkg::OP_ADD, R_AA, R_T, 1'b1, 2'd2, R_S};
      5'd16: u = '{gakf_pkg::OP_ADD, R_AA, R_T, 1'b1, 2'd3, R_P00};
      5'd17: u = '{gakf_pkg::OP_ADD, R_AB, R_T, 1'b1, 2'd3, R_P01};
      5'd21: u = '{gakf_pkg::OP_ADD, R_AA, R_S, 1'b0, 2'd0, R_K0};
      5'd22: u = '{gakf_pkg::OP_ADD, R_BA, R_S, 1'b0, 2'd0, R_K1};
      5'd18: u = '{gakf_pkg::OP_ADD, R_T, R_T, 1'b1, 2'd3, R_T};
      5'd19: u = '{gakf_pkg::OP_ADD, R_T, R_T, 1'b1, 2'd3, R_T};
      5'd20: u = '{gakf_pkg::OP_ADD, R_T, R_T, 1'b1, 2'd3, R_T};
      5'd23: u = '{gakf_pkg::OP_MUL, R_K0, R_U, 1'b0, 2'd0, R_T};
      5'd24: u = '{gakf_pkg::OP_ADD, R_ANG, R_T, 1'b0, 2'd0, R_ANG};
      5'd25: u = '{gakf_pkg::OP_MUL, R_K1, R_U, 1'b0, 2'd0, R_T};
      5'd26: u = '{gakf_pkg::OP_ADD, R_BIAS, R_T, 1'b0, 2'd0, R_BIAS};
      5'd27: u = '{gakf_pkg::OP_MUL, R_K0, R_P00, 1'b0, 2'd0, R_T};
      default: u = '{gakf_pkg::OP_ADD, R_T, R_T, 1'b1, 2'd3, R_T};
    endcase
  end

  // covariance tail: four multiply/subtract pairs, run after the program
  typedef struct packed {
    reg_t k;
    reg_t p;
    reg_t d;
  } tail_t;

  logic [2:0] tpc;
  logic in_tail;
  tail_t tl;
  reg_t a_sel, b_sel, d_sel;
  gakf_pkg::alu_op_t op_sel;
  logic sub_phase;

  always_comb begin
    tl = '{R_K0, R_P00, R_AA};
    unique case (tpc[2:1])
      2'd0: tl = '{R_K0, R_P00, R_AA};
      2'd1: tl = '{R_K0, R_P01, R_AB};
      2'd2: tl = '{R_K1, R_P00, R_BA};
      2'd3: tl = '{R_K1, R_P01, R_BB};
      default: tl = '{R_K0, R_P00, R_AA};
    endcase
    sub_phase = tpc[0];
    if (in_tail) begin
      op_sel = sub_phase ? gakf_pkg::OP_SUB : gakf_pkg::OP_MUL;
      a_sel = sub_phase ? tl.d : tl.k;
      b_sel = sub_phase ? R_T : tl.p;
      d_sel = sub_phase ? tl.d : R_T;
    end else begin
      op_sel = u.op;
      a_sel = u.a;
      b_sel = u.b;
      d_sel = u.d;
    end
    opa = rf[a_sel];
    opb = rf[b_sel];
    if (!in_tail && u.b_cfg) begin
      unique case (u.cfg_sel)
        2'd0: opb = $signed({8'd0, q_angle});
        2'd1: opb = $signed({8'd0, q_bias});
        2'd2: opb = $signed({8'd0, r_meas});
        default: opb = '0;
      endcase
    end
  end

  gakf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .op(op_sel), .a(opa), .b(opb), .res(alu_res)
  );

  assign div_start = (state == S_ISSUE) && !in_tail &&
                     ((pc == PCW'(DIV0)) || (pc == PCW'(DIV1)));

  gakf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(opa), .den(opb), .done(div_done), .quo(div_q)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign angle_estimate = rf[R_ANG];
  assign bias_estimate = rf[R_BIAS];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pc <= '0;
      tpc <= '0;
      in_tail <= 1'b0;
      q_angle <= gakf_pkg::Q_ANGLE_RST;
      q_bias <= gakf_pkg::Q_BIAS_RST;
      r_meas <= gakf_pkg::R_MEAS_RST;
      for (int i = 0; i < 16; i++) begin
        rf[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          gakf_pkg::REG_Q_ANGLE: q_angle <= cfg_data;
          gakf_pkg::REG_Q_BIAS:  q_bias <= cfg_data;
          gakf_pkg::REG_R_MEAS:  r_meas <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rf[R_RATE] <= rate_sample;
            rf[R_MEAS] <= measured_angle;
            rf[R_DT] <= $signed({12'd0, time_step});
            pc <= '0;
            tpc <= '0;
            in_tail <= 1'b0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (div_start) begin
            state <= S_DIV;
          end else if (!in_tail && (pc == PCW'(16) || pc == PCW'(17))) begin
            // snapshot pre-update covariance
            rf[d_sel] <= opa;
            pc <= pc + 1'b1;
          end else if (!in_tail && (pc == PCW'(18) || pc == PCW'(19) || pc == PCW'(20))) begin
            pc <= pc + 1'b1;
          end else begin
            state <= S_WB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            rf[d_sel] <= div_q;
            pc <= pc + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_WB: begin
          rf[d_sel] <= alu_res;
          if (in_tail) begin
            tpc <= tpc + 1'b1;
            if (tpc == 3'd7) begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              state <= S_ISSUE;
            end
          end else begin
            state <= S_ISSUE;
            if (pc == PCW'(26)) begin
              in_tail <= 1'b1;
              tpc <= '0;
            end else begin
              pc <= pc + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, !out_valid, "ready while result pending")
  `ASSERT_IMPL(a_out_state, clk, rst, out_valid, state == S_OUT, "valid outside output state")
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready, "accepted twice")

endmodule

FILE: tb/gakf_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the filter, tracks its state and
// compares every output word with the predicted estimates.
module gakf_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [gakf_pkg::DATA_W-1:0]  rate_sample,
  input  logic signed [gakf_pkg::DATA_W-1:0]  measured_angle,
  input  logic [gakf_pkg::DT_W-1:0]           time_step,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [gakf_pkg::DATA_W-1:0]  angle_estimate,
  input  logic signed [gakf_pkg::DATA_W-1:0]  bias_estimate,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [gakf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gakf_pkg::REG_W-1:0]          cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  words_checked
);
  import gakf_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [DATA_W-1:0] angle;
    logic signed [DATA_W-1:0] bias;
  } estimate_t;

  estimate_t estimates_due[$];

  // filter registers and state
  longint q_angle, q_bias, r_meas;
  longint angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;

  function automatic longint clip(longint v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return clip(a - b);
  endfunction

  // round half up, arithmetic shift gives floor
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FB - 1));
    return clip(p >>> FB);
  endfunction

  // signed divide truncating toward zero; zero divisor gives zero gain
  function automatic longint qdiv(longint a, longint b);
    if (b == 0) return 0;
    return clip((a <<< FB) / b);
  endfunction

  // one filter iteration: predict, then update
  function automatic estimate_t kalman_iterate(longint rate, longint meas, longint dt);
    longint t, dt2, y, s, k0, k1, p00, p01;
    estimate_t e;
    angle_st = qadd(angle_st, qmul(dt, qsub(rate, bias_st)));
    t = qmul(dt, qadd(p_ba, p_ab));
    dt2 = qmul(dt, dt);
    p_aa = qadd(qadd(qsub(p_aa, t), qmul(dt2, p_bb)), q_angle);
    t = qmul(dt, p_bb);
    p_ab = qsub(p_ab, t);
    p_ba = qsub(p_ba, t);
    p_bb = qadd(p_bb, q_bias);

    y = qsub(meas, angle_st);
    s = qadd(p_aa, r_meas);
    k0 = qdiv(p_aa, s);
    k1 = qdiv(p_ba, s);
    angle_st = qadd(angle_st, qmul(k0, y));
    bias_st = qadd(bias_st, qmul(k1, y));
    p00 = p_aa;
    p01 = p_ab;
    p_aa = qsub(p00, qmul(k0, p00));
    p_ab = qsub(p01, qmul(k0, p01));
    p_ba = qsub(p_ba, qmul(k1, p00));
    p_bb = qsub(p_bb, qmul(k1, p01));
    e.angle = angle_st[DATA_W-1:0];
    e.bias = bias_st[DATA_W-1:0];
    return e;
  endfunction

  always @(posedge clk) begin
    estimate_t want;
    if (rst) begin
      q_angle = longint'(Q_ANGLE_RST);
      q_bias = longint'(Q_BIAS_RST);
      r_meas = longint'(R_MEAS_RST);
      angle_st = 0; bias_st = 0;
      p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      estimates_due.delete();
      errors <= 0;
      words_checked <= 0;
      pending <= 0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_Q_ANGLE: q_angle = longint'(cfg_data);
          REG_Q_BIAS:  q_bias = longint'(cfg_data);
          REG_R_MEAS:  r_meas = longint'(cfg_data);
          default: ;
        endcase
      end
      // input word: predict its estimates
      if (in_valid && in_ready)
        estimates_due.push_back(kalman_iterate(longint'(rate_sample),
                                               longint'(measured_angle),
                                               longint'(time_step)));
      // output word: compare with the oldest prediction
      if (out_valid && out_ready) begin
        words_checked <= words_checked + 1;
        if (estimates_due.size() == 0) begin
          $display("%0t: unexpected output word angle=%0d bias=%0d",
                   $time, angle_estimate, bias_estimate);
          errors <= errors + 1;
        end else begin
          want = estimates_due.pop_front();
          if (want.angle !== angle_estimate || want.bias !== bias_estimate) begin
            $display("%0t: mismatch angle exp=%0d got=%0d, bias exp=%0d got=%0d",
                     $time, want.angle, angle_estimate, want.bias, bias_estimate);
            errors <= errors + 1;
          end
        end
      end
      // words predicted but not yet seen
      pending <= estimates_due.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gakf_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [REG_W-1:0] REG_FULL = 24'hffffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] rate_sample = '0;
  logic signed [DATA_W-1:0] measured_angle = '0;
  logic [DT_W-1:0] time_step = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] angle_estimate;
  logic signed [DATA_W-1:0] bias_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  int errors, pending, words_checked;
  int words_sent = 0;
  int settings_run = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  gyro_angle_kalman_filter uut (.*);

  gakf_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // output side: random stall bursts, none in the calm tail
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(0, 13));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // hand one word to the filter; valid stays high afterwards
  task automatic send_word(logic signed [DATA_W-1:0] rate, logic signed [DATA_W-1:0] meas,
                           logic [DT_W-1:0] dt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rate_sample <= rate;
    measured_angle <= meas;
    time_step <= dt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // drop valid and wait for every expected word, then a short settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_noise(logic [REG_W-1:0] qa, logic [REG_W-1:0] qb,
                            logic [REG_W-1:0] r);
    write_reg(REG_Q_ANGLE, qa);
    write_reg(REG_Q_BIAS, qb);
    write_reg(REG_R_MEAS, r);
    settings_run++;
  endtask

  // mostly realistic samples, some full-range noise
  task automatic random_words(int n);
    logic signed [DATA_W-1:0] rate, meas;
    logic [DT_W-1:0] dt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        rate = $urandom;
        meas = $urandom;
        dt = DT_W'($urandom);
      end else begin
        rate = $signed($urandom_range(0, 2 * 655360)) - 655360;
        meas = $signed($urandom_range(0, 2 * 5898240)) - 5898240;
        dt = ($urandom_range(0, 9) == 0) ? DT_W'($urandom_range(0, 20'hfffff))
                                         : DT_W'($urandom_range(0, 6554));
      end
      send_word(rate, meas, dt);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero noise from reset: divisor is zero on the first word
    load_noise('0, '0, '0);
    send_word(32'sd65536, 32'sd131072, '0);
    send_word(32'sd0, 32'sd65536, 20'd655);
    drain();

    // defaults, field extremes
    load_noise(Q_ANGLE_RST, Q_BIAS_RST, R_MEAS_RST);
    send_word('0, '0, '0);
    send_word(MAX32, MIN32, 20'hfffff);
    send_word(MIN32, MAX32, 20'hfffff);
    send_word(MAX32, MAX32, 20'd1);
    send_word(MIN32, MIN32, 20'd65536);
    send_word(-32'sd1, 32'sd1, 20'h80000);
    send_word(32'sd6553, -32'sd3276800, 20'd655);
    send_word(32'sh55555555, 32'shaaaaaaaa, 20'h55555);
    send_word(32'shaaaaaaaa, 32'sh55555555, 20'haaaaa);
    random_words(60);
    drain();

    // smallest legal noise, then the unused index
    load_noise('0, '0, 24'd1);
    write_reg(REG_UNUSED, REG_W'($urandom));
    random_words(100);
    drain();

    // largest noise
    load_noise(REG_FULL, REG_FULL, REG_FULL);
    random_words(100);
    drain();

    // random noise settings
    load_noise(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom_range(1, REG_FULL)));
    random_words(120);
    drain();

    // back to defaults, no idling on either side
    load_noise(Q_ANGLE_RST, Q_BIAS_RST, R_MEAS_RST);
    calm = 1'b1;
    random_words(100);
    drain();

    $display("Sent %0d words under %0d noise settings, checked %0d output words.",
             words_sent, settings_run, words_checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
